[rtl/core/fsbi_pkg.sv]
package fsbi_pkg;
  localparam int MAX_BODIES   = 16;
  localparam int MAX_SUBSTEPS = 4;
  localparam int IDX_W  = $clog2(MAX_BODIES);
  localparam int CNT_W  = $clog2(MAX_BODIES + 1);
  localparam int SUB_W  = $clog2(MAX_SUBSTEPS + 1);
  localparam int ACC_W  = 40;
  localparam int CFG_AW = 3;

  localparam logic [CFG_AW-1:0] REG_GRAV_X = 3'd0;
  localparam logic [CFG_AW-1:0] REG_GRAV_Y = 3'd1;
  localparam logic [CFG_AW-1:0] REG_DAMP_X = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DAMP_Y = 3'd3;
  localparam logic [CFG_AW-1:0] REG_STEP   = 3'd4;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] init_pos_x;
    logic signed [31:0] init_pos_y;
    logic signed [31:0] init_vel_x;
    logic signed [31:0] init_vel_y;
    logic [30:0]       frame_delta;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic              status;
    logic              body_valid;
    logic [3:0]        body_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [2:0]        substeps_run;
    logic              last;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

[rtl/core/fsbi_if.sv]
interface fsbi_in_if;
  import fsbi_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fsbi_out_if;
  import fsbi_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/fsbi_mulq.sv]
// One registered signed 32 x unsigned 31/17 product, >>16 floor, saturated.
module fsbi_mulq (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic [30:0]        b,
  output logic signed [31:0] q_r
);
  import fsbi_pkg::*;
  logic signed [63:0] p;
  logic signed [47:0] sh;
  assign p  = a * $signed({1'b0, b});
  assign sh = p[63:16];
  always_ff @(posedge clk) begin
    if (sh > 48'sd2147483647) q_r <= 32'sh7fffffff;
    else if (sh < -48'sd2147483648) q_r <= 32'sh80000000;
    else q_r <= sh[31:0];
  end
endmodule

[rtl/core/fixed_step_body_integrator.sv]
// Add: result presented the cycle after the accepting edge.
// Tick: each substep runs check, then GX, GY, GW once, then RD, VA, DX, DY, PX, PY, WB per body;
// a final check presents the first result, then one result per cycle while taken.
// One transaction at a time: ready only in idle. The shared registered multiplier,
// four products per body per substep plus two gravity products per substep, sets the per-body cost.
// Synchronous active-low reset clears count, accumulator and sequencer and sets config to its defaults.
module fixed_step_body_integrator (
  input  logic              clk,
  input  logic              rst_n,
  fsbi_in_if.sink           in_ch,
  fsbi_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [fsbi_pkg::CFG_AW-1:0] cfg_index,
  input  logic [31:0]       cfg_data
);
  import fsbi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_GX, S_GY, S_GW, S_RD, S_VA, S_DX, S_DY, S_PX, S_PY, S_WB, S_OUT
  } state_t;

  state_t state_r;
  logic signed [31:0] grav_x_r, grav_y_r;
  logic [16:0] damp_x_r, damp_y_r;
  logic [30:0] step_r;
  logic [ACC_W-1:0] acc_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] idx_r;    // zero whenever the sequencer is in idle or check
  logic [SUB_W-1:0] sub_r;
  logic signed [31:0] gix_r, giy_r, vx_r, vy_r, px_r, py_r;

  // body table, undefined until written
  logic signed [31:0] mem_px [MAX_BODIES];
  logic signed [31:0] mem_py [MAX_BODIES];
  logic signed [31:0] mem_vx [MAX_BODIES];
  logic signed [31:0] mem_vy [MAX_BODIES];

  logic signed [31:0] mul_a, mul_q;
  logic [30:0] mul_b;
  logic [ACC_W:0] acc_sum;
  logic step_due;
  logic add_ok;
  logic [IDX_W-1:0] idx_nxt;
  logic last_body, last_next;
  logic signed [31:0] vx_g, vy_g, px_new, py_new;

  function automatic out_item_t pack_item(logic rk, logic st, logic bv,
                                          logic [IDX_W-1:0] idx,
                                          logic signed [31:0] px, py, vx, vy,
                                          logic [SUB_W-1:0] sub, logic lst);
    out_item_t it;
    it.result_kind  = rk;
    it.status       = st;
    it.body_valid   = bv;
    it.body_index   = 4'(idx);
    it.pos_x        = px;
    it.pos_y        = py;
    it.vel_x        = vx;
    it.vel_y        = vy;
    it.substeps_run = 3'(sub);
    it.last         = lst;
    return it;
  endfunction

  // shared multiplier operand select; the product is valid in the following state
  always_comb begin
    case (state_r)
      S_GX:    begin mul_a = grav_x_r; mul_b = step_r; end
      S_GY:    begin mul_a = grav_y_r; mul_b = step_r; end
      S_DX:    begin mul_a = vx_r; mul_b = {14'd0, damp_x_r}; end
      S_DY:    begin mul_a = vy_r; mul_b = {14'd0, damp_y_r}; end
      S_PX:    begin mul_a = vx_r; mul_b = step_r; end
      S_PY:    begin mul_a = vy_r; mul_b = step_r; end
      default: begin mul_a = grav_x_r; mul_b = step_r; end
    endcase
  end
  fsbi_mulq u_mul (.clk(clk), .a(mul_a), .b(mul_b), .q_r(mul_q));

  assign acc_sum   = {1'b0, acc_r} + (ACC_W+1)'(in_ch.data.frame_delta);
  assign step_due  = (sub_r < SUB_W'(MAX_SUBSTEPS)) && (acc_r >= ACC_W'(step_r));
  assign add_ok    = count_r < CNT_W'(MAX_BODIES);
  assign idx_nxt   = idx_r + IDX_W'(1);
  assign last_body = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
  assign last_next = (CNT_W'(idx_r) + CNT_W'(2)) == count_r;
  assign vx_g      = sat32(34'(vx_r) + 34'(gix_r));
  assign vy_g      = sat32(34'(vy_r) + 34'(giy_r));
  assign px_new    = sat32(34'(px_r) + 34'(mul_q));
  assign py_new    = sat32(34'(py_r) + 34'(mul_q));

  assign in_ch.ready = (state_r == S_IDLE);

  // table writes: append on an accepted add when not full, write back after each body update
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.data.kind == KIND_ADD && add_ok) begin
      mem_px[count_r[IDX_W-1:0]] <= in_ch.data.init_pos_x;
      mem_py[count_r[IDX_W-1:0]] <= in_ch.data.init_pos_y;
      mem_vx[count_r[IDX_W-1:0]] <= in_ch.data.init_vel_x;
      mem_vy[count_r[IDX_W-1:0]] <= in_ch.data.init_vel_y;
    end else if (state_r == S_WB) begin
      mem_vx[idx_r] <= vx_r;
      mem_vy[idx_r] <= vy_r;
      mem_px[idx_r] <= px_r;
      mem_py[idx_r] <= py_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      grav_x_r <= '0; grav_y_r <= '0;
      damp_x_r <= 17'd65536; damp_y_r <= 17'd65536;
      step_r <= 31'd1092;
      acc_r <= '0; count_r <= '0; idx_r <= '0; sub_r <= '0;
      out_ch.valid <= 1'b0;
      out_ch.data <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRAV_X: grav_x_r <= cfg_data;
          REG_GRAV_Y: grav_y_r <= cfg_data;
          REG_DAMP_X: damp_x_r <= cfg_data[16:0];
          REG_DAMP_Y: damp_y_r <= cfg_data[16:0];
          REG_STEP:   step_r   <= cfg_data[30:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.data.kind == KIND_ADD) begin
              out_ch.valid <= 1'b1;
              if (add_ok) begin
                out_ch.data <= pack_item(KIND_ADD, STATUS_OK, 1'b1, count_r[IDX_W-1:0],
                                         in_ch.data.init_pos_x, in_ch.data.init_pos_y,
                                         in_ch.data.init_vel_x, in_ch.data.init_vel_y,
                                         '0, 1'b1);
                count_r <= count_r + CNT_W'(1);
              end else begin
                // table full: body dropped, empty acknowledgement
                out_ch.data <= pack_item(KIND_ADD, STATUS_FULL, 1'b0, '0,
                                         '0, '0, '0, '0, '0, 1'b1);
              end
              state_r <= S_OUT;
            end else begin
              // accumulator saturates at all ones
              acc_r <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
              sub_r <= '0;
              state_r <= S_CHK;
            end
          end
        end
        S_CHK: begin
          if (step_due) begin
            acc_r <= acc_r - ACC_W'(step_r);
            sub_r <= sub_r + SUB_W'(1);
            if (count_r != '0) state_r <= S_GX;
          end else begin
            out_ch.valid <= 1'b1;
            if (count_r == '0) begin
              out_ch.data <= pack_item(KIND_TICK, STATUS_OK, 1'b0, '0,
                                       '0, '0, '0, '0, sub_r, 1'b1);
            end else begin
              out_ch.data <= pack_item(KIND_TICK, STATUS_OK, 1'b1, idx_r,
                                       mem_px[idx_r], mem_py[idx_r],
                                       mem_vx[idx_r], mem_vy[idx_r], sub_r, last_body);
            end
            state_r <= S_OUT;
          end
        end
        // gravity times interval, once per substep
        S_GX: state_r <= S_GY;
        S_GY: begin gix_r <= mul_q; state_r <= S_GW; end
        S_GW: begin giy_r <= mul_q; state_r <= S_RD; end
        S_RD: begin
          vx_r <= mem_vx[idx_r];
          vy_r <= mem_vy[idx_r];
          px_r <= mem_px[idx_r];
          py_r <= mem_py[idx_r];
          state_r <= S_VA;
        end
        S_VA: begin
          vx_r <= vx_g;
          vy_r <= vy_g;
          state_r <= S_DX;
        end
        S_DX: state_r <= S_DY;
        S_DY: begin vx_r <= mul_q; state_r <= S_PX; end   // damped vx
        S_PX: begin vy_r <= mul_q; state_r <= S_PY; end   // damped vy
        S_PY: begin px_r <= px_new; state_r <= S_WB; end
        S_WB: begin
          // py is finished on the write port
          if (last_body) begin
            idx_r <= '0;
            state_r <= S_CHK;
          end else begin
            idx_r <= idx_nxt;
            state_r <= S_RD;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (out_ch.data.last) begin
              out_ch.valid <= 1'b0;
              idx_r <= '0;
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_nxt;
              out_ch.data <= pack_item(KIND_TICK, STATUS_OK, 1'b1, idx_nxt,
                                       mem_px[idx_nxt], mem_py[idx_nxt],
                                       mem_vx[idx_nxt], mem_vy[idx_nxt], sub_r, last_next);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BODIES)) else $error("body count overflow");
  a_sub_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.data.substeps_run <= 3'(MAX_SUBSTEPS))
    else $error("too many substeps");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
endmodule
